### hdl/bssq_pkg.sv
// Package for the bounded sorted score queue.
// Holds the field widths, register codes, function codes, state type and
// the transfer structs that the modules of the block share.
package bssq_pkg;

  localparam int SCORE_W = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int SIZE_W  = 5;
  localparam int INDEX_W = 4;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic signed [SCORE_W-1:0] SCORE_LIMIT_RST = 32'sh7FFF_FFFF;
  localparam logic [SIZE_W-1:0]         SIZE_RST        = 5'd16;

  localparam logic REG_SCORE_LIMIT = 1'b0;
  localparam logic REG_SIZE_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    func_e                      func;
    logic signed [SCORE_W-1:0]  score;
    logic signed [VALUE_W-1:0]  first_value;
    logic signed [VALUE_W-1:0]  second_value;
    logic [INDEX_W-1:0]         read_index;
  } item_t;

  typedef struct packed {
    logic                       accepted;
    logic                       is_full;
    logic [COUNT_W-1:0]         entry_count;
    logic                       read_valid;
    logic signed [SCORE_W-1:0]  read_score;
    logic signed [VALUE_W-1:0]  read_first;
    logic signed [VALUE_W-1:0]  read_second;
  } result_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0]  score_limit;
    logic [SIZE_W-1:0]          size_in_use;
    logic                       trunc;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

### hdl/bssq_regs.sv
// Configuration registers of the bounded sorted score queue.
// APB-style write and read port; depends on bssq_pkg.
module bssq_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bssq_pkg::ADDR_W-1:0]  paddr,
  input  logic [bssq_pkg::DATA_W-1:0]  pwdata,
  output logic [bssq_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output bssq_pkg::cfg_t               cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_limit <= bssq_pkg::SCORE_LIMIT_RST;
      cfg.size_in_use <= bssq_pkg::SIZE_RST;
      cfg.trunc       <= 1'b0;
    end else begin
      cfg.trunc <= wr && (paddr[2] == bssq_pkg::REG_SIZE_IN_USE);
      if (wr) begin
        unique case (paddr[2])
          bssq_pkg::REG_SCORE_LIMIT: cfg.score_limit <= pwdata;
          bssq_pkg::REG_SIZE_IN_USE: cfg.size_in_use <= pwdata[bssq_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[2])
      bssq_pkg::REG_SCORE_LIMIT: prdata = cfg.score_limit;
      bssq_pkg::REG_SIZE_IN_USE: prdata = bssq_pkg::DATA_W'(cfg.size_in_use);
      default:                   prdata = '0;
    endcase
  end

endmodule

### hdl/bssq_ctrl.sv
// Controller of the bounded sorted score queue.
// Sequences capture and execution of one item; depends on bssq_pkg.
module bssq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output bssq_pkg::cmd_t  cmd
);

  bssq_pkg::state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bssq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    unique case (state)
      bssq_pkg::ST_IDLE: state_next = start ? bssq_pkg::ST_EXEC : bssq_pkg::ST_IDLE;
      bssq_pkg::ST_EXEC: state_next = bssq_pkg::ST_IDLE;
      default:           state_next = bssq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      bssq_pkg::ST_IDLE: cmd.capture = start;
      bssq_pkg::ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### hdl/bssq_dp.sv
// Datapath of the bounded sorted score queue: a chain of slot cells that
// all compare and shift at once, the entry count and the result register.
// Depends on bssq_pkg.
module bssq_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  bssq_pkg::cmd_t     cmd,
  input  bssq_pkg::cfg_t     cfg,
  input  bssq_pkg::item_t    item,
  output logic               done,
  output bssq_pkg::result_t  result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = (CW > bssq_pkg::SIZE_W) ? CW : bssq_pkg::SIZE_W;
  localparam int XW = (CW > bssq_pkg::INDEX_W) ? CW : bssq_pkg::INDEX_W;
  localparam int RW = (IW > bssq_pkg::INDEX_W) ? IW : bssq_pkg::INDEX_W;

  logic signed [bssq_pkg::SCORE_W-1:0] slot_score  [DEPTH];
  logic signed [bssq_pkg::VALUE_W-1:0] slot_first  [DEPTH];
  logic signed [bssq_pkg::VALUE_W-1:0] slot_second [DEPTH];
  logic signed [bssq_pkg::SCORE_W-1:0] prev_score  [DEPTH];
  logic signed [bssq_pkg::VALUE_W-1:0] prev_first  [DEPTH];
  logic signed [bssq_pkg::VALUE_W-1:0] prev_second [DEPTH];

  bssq_pkg::item_t   item_q;
  bssq_pkg::result_t result_next;

  logic [CW-1:0]    held, held_next, cap, cap_m1;
  logic [SW-1:0]    size_x;
  logic [XW-1:0]    idx_x, held_x;
  logic [RW-1:0]    ridx_w;
  logic [IW-1:0]    ridx;
  logic [DEPTH-1:0] place, place_prev, take_new, wen;
  logic             is_ins, is_rd, is_clr, ins_ok, rd_ok;

  always_comb begin
    size_x = SW'(cfg.size_in_use);
    if (size_x == '0) begin
      cap = CW'(1);
    end else if (size_x > SW'(DEPTH)) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(size_x);
    end
    cap_m1 = cap - CW'(1);
  end

  always_comb begin
    is_ins = 1'b0;
    is_rd  = 1'b0;
    is_clr = 1'b0;
    unique case (item_q.func)
      bssq_pkg::FUNC_INSERT: is_ins = cmd.execute;
      bssq_pkg::FUNC_READ:   is_rd  = cmd.execute;
      bssq_pkg::FUNC_CLEAR:  is_clr = cmd.execute;
      default: ;
    endcase
  end

  // A cell lies at or after the insert point when it is empty or holds a
  // greater score; the table is sorted, so these cells form one run.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      place[i] = (CW'(i) >= held) || (slot_score[i] > item_q.score);
    end
    place_prev = DEPTH'({place, 1'b0});
    take_new   = place & ~place_prev;
    ins_ok     = is_ins && (item_q.score < cfg.score_limit) && place[cap_m1[IW-1:0]];
    for (int i = 0; i < DEPTH; i++) begin
      wen[i] = ins_ok && (CW'(i) < cap) && place[i];
    end
  end

  always_comb begin
    prev_score[0]  = item_q.score;
    prev_first[0]  = item_q.first_value;
    prev_second[0] = item_q.second_value;
    for (int i = 1; i < DEPTH; i++) begin
      prev_score[i]  = slot_score[i-1];
      prev_first[i]  = slot_first[i-1];
      prev_second[i] = slot_second[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (wen[i]) begin
        slot_score[i]  <= take_new[i] ? item_q.score        : prev_score[i];
        slot_first[i]  <= take_new[i] ? item_q.first_value  : prev_first[i];
        slot_second[i] <= take_new[i] ? item_q.second_value : prev_second[i];
      end
    end
  end

  always_comb begin
    held_next = held;
    priority if (cfg.trunc && (held > cap)) begin
      held_next = cap;
    end else if (is_clr) begin
      held_next = '0;
    end else if (ins_ok && (held < cap)) begin
      held_next = held + CW'(1);
    end
  end

  always_comb begin
    idx_x  = XW'(item_q.read_index);
    held_x = XW'(held);
    ridx_w = RW'(item_q.read_index);
    ridx   = ridx_w[IW-1:0];
    rd_ok  = is_rd && (idx_x < held_x);

    result_next.accepted    = ins_ok;
    result_next.is_full     = held_next >= cap;
    result_next.entry_count = bssq_pkg::COUNT_W'(held_next);
    result_next.read_valid  = rd_ok;
    result_next.read_score  = rd_ok ? slot_score[ridx]  : '0;
    result_next.read_first  = rd_ok ? slot_first[ridx]  : '0;
    result_next.read_second = rd_ok ? slot_second[ridx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      done <= 1'b0;
    end else begin
      held <= held_next;
      done <= cmd.execute;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (cmd.execute) begin
      result <= result_next;
    end
  end

endmodule

### hdl/bounded_sorted_score_queue.sv
// Bounded sorted score queue, top level: registers, controller, datapath.
// A result strobes on done once the item taken at start is captured and executed.
// The block takes no new item while busy; busy is high for the execute cycle
// in which the slot chain compares and shifts all cells at once.
// Reset (rst, synchronous) empties the table and restores the registers;
// slot contents stay undefined. Results cannot be stalled by the receiver.
module bounded_sorted_score_queue #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  bssq_pkg::item_t              item,
  output logic                         done,
  output bssq_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bssq_pkg::ADDR_W-1:0]  paddr,
  input  logic [bssq_pkg::DATA_W-1:0]  pwdata,
  output logic [bssq_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  bssq_pkg::cfg_t cfg;
  bssq_pkg::cmd_t cmd;

  bssq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bssq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  bssq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .item   (item),
    .done   (done),
    .result (result)
  );

endmodule

### hdl/bssq_chk.sv
// Port checker for the bounded sorted score queue and its bind statement.
// Watches start, busy, done and the result struct; depends on bssq_pkg.
module bssq_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input bssq_pkg::result_t  result
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted item");

  a_done_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing two cycles after an accepted item");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the cycle after execution");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.read_valid) |->
      (result.read_score == '0) && (result.read_first == '0) &&
      (result.read_second == '0))
    else $error("read fields nonzero on a result without a valid read");

  a_accept_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |-> (result.entry_count != '0) && !result.read_valid)
    else $error("accepted insert reported an empty table or a read");

endmodule

bind bounded_sorted_score_queue bssq_chk u_bssq_chk (.*);

### tb/testbench.sv
// Self-checking testbench for the bounded sorted score queue.
// Drives items and register writes, predicts each result from its own table
// model, and compares every transfer on done; needs only bssq_pkg and the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                start = 1'b0;
  logic                                busy;
  bssq_pkg::item_t                     item = '0;
  logic                                done;
  bssq_pkg::result_t                   result;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [bssq_pkg::ADDR_W-1:0]         paddr = '0;
  logic [bssq_pkg::DATA_W-1:0]         pwdata = '0;
  logic [bssq_pkg::DATA_W-1:0]         prdata;
  logic                                pready;

  bssq_pkg::item_t                     pending_items[$];
  bssq_pkg::result_t                   expected_results[$];
  int                                  items_queued = 0;
  int                                  results_seen = 0;
  int                                  idle_pct = 0;
  int                                  err_count = 0;
  int                                  cycle_count = 0;

  logic signed [bssq_pkg::SCORE_W-1:0] held_score[SLOTS];
  logic signed [bssq_pkg::VALUE_W-1:0] held_first[SLOTS];
  logic signed [bssq_pkg::VALUE_W-1:0] held_second[SLOTS];
  int                                  held_count = 0;
  logic signed [bssq_pkg::SCORE_W-1:0] cfg_max = bssq_pkg::SCORE_LIMIT_RST;
  logic [bssq_pkg::SIZE_W-1:0]         cfg_size = bssq_pkg::SIZE_RST;

  bounded_sorted_score_queue #(.DEPTH(SLOTS)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int slot_capacity();
    if (cfg_size < 1) return 1;
    if (cfg_size > SLOTS) return SLOTS;
    return int'(cfg_size);
  endfunction

  function automatic bssq_pkg::result_t table_outcome(input bssq_pkg::item_t it);
    bssq_pkg::result_t r;
    int                cap;
    int                k;
    int                last;
    r = '0;
    cap = slot_capacity();
    if (held_count > cap) held_count = cap;
    case (it.func)
      bssq_pkg::FUNC_INSERT: begin
        if ($signed(it.score) < $signed(cfg_max)) begin
          k = 0;
          while (k < held_count && $signed(held_score[k]) <= $signed(it.score)) k++;
          if (k < cap) begin
            last = (held_count < cap) ? held_count : cap - 1;
            for (int i = last; i > k; i--) begin
              held_score[i]  = held_score[i-1];
              held_first[i]  = held_first[i-1];
              held_second[i] = held_second[i-1];
            end
            held_score[k]  = it.score;
            held_first[k]  = it.first_value;
            held_second[k] = it.second_value;
            if (held_count < cap) held_count++;
            r.accepted = 1'b1;
          end
        end
      end
      bssq_pkg::FUNC_READ: begin
        if (int'(it.read_index) < held_count) begin
          r.read_valid  = 1'b1;
          r.read_score  = held_score[it.read_index];
          r.read_first  = held_first[it.read_index];
          r.read_second = held_second[it.read_index];
        end
      end
      bssq_pkg::FUNC_CLEAR: begin
        held_count = 0;
      end
      default: ;
    endcase
    r.is_full = (held_count >= cap);
    r.entry_count = bssq_pkg::COUNT_W'(held_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      err_count++;
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, name, got, want);
    end
  endtask

  function automatic bssq_pkg::item_t make_item(input bssq_pkg::func_e f,
                                                input logic [31:0] s,
                                                input logic [31:0] v1,
                                                input logic [31:0] v2,
                                                input logic [bssq_pkg::INDEX_W-1:0] idx);
    bssq_pkg::item_t it;
    it.func = f;
    it.score = s;
    it.first_value = v1;
    it.second_value = v2;
    it.read_index = idx;
    return it;
  endfunction

  function automatic logic [31:0] rand_score();
    logic [31:0] s;
    case ($urandom_range(0, 4))
      0, 1: s = $urandom;
      2: s = (int'($urandom_range(0, 16)) - 8) * 65536;
      3: begin
        case ($urandom_range(0, 3))
          0: s = 32'h8000_0000;
          1: s = 32'h7FFF_FFFF;
          2: s = 32'h0000_0000;
          default: s = 32'hFFFF_FFFF;
        endcase
      end
      default: s = cfg_max + $urandom_range(0, 4) - 2;
    endcase
    return s;
  endfunction

  task automatic queue_item(input bssq_pkg::item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic fill_random(input int n);
    int              roll;
    bssq_pkg::func_e f;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) f = bssq_pkg::FUNC_CLEAR;
      else if (roll < 60) f = bssq_pkg::FUNC_INSERT;
      else f = bssq_pkg::FUNC_READ;
      queue_item(make_item(f, rand_score(), $urandom, $urandom,
                           bssq_pkg::INDEX_W'($urandom_range(0, 15))));
    end
  endtask

  task automatic wait_drained();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_sel, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == bssq_pkg::REG_SCORE_LIMIT) begin
      cfg_max = value;
      want = value;
    end else begin
      cfg_size = value[bssq_pkg::SIZE_W-1:0];
      want = {{(32-bssq_pkg::SIZE_W){1'b0}}, value[bssq_pkg::SIZE_W-1:0]};
      if (held_count > slot_capacity()) held_count = slot_capacity();
    end
    check_field("register readback", readback, want);
  endtask

  task automatic run_phase(input logic [31:0] max_val,
                           input logic [bssq_pkg::SIZE_W-1:0] size_val,
                           input int idle, input int n);
    write_register(bssq_pkg::REG_SCORE_LIMIT, max_val);
    write_register(bssq_pkg::REG_SIZE_IN_USE, {{(32-bssq_pkg::SIZE_W){1'b0}}, size_val});
    idle_pct = idle;
    fill_random(n / 2);
    wait_drained();
    fill_random(n - n / 2);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) expected_results.push_back(table_outcome(item));
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    bssq_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        check_field("transfer with nothing outstanding", 32'd1, 32'd0);
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        check_field("accepted", 32'(result.accepted), 32'(want.accepted));
        check_field("is_full", 32'(result.is_full), 32'(want.is_full));
        check_field("entry_count", 32'(result.entry_count), 32'(want.entry_count));
        check_field("read_valid", 32'(result.read_valid), 32'(want.read_valid));
        check_field("read_score", result.read_score, want.read_score);
        check_field("read_first", result.read_first, want.read_first);
        check_field("read_second", result.read_second, want.read_second);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_item(make_item(bssq_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h7FFF_FFFF, $urandom, $urandom, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 4'd15));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h7FFF_FFFE, 32'h0, 32'hFFFF_FFFF, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h0, $urandom, $urandom, 4'd0));
    for (int i = 0; i < 5; i++) begin
      queue_item(make_item(bssq_pkg::FUNC_READ, $urandom, $urandom, $urandom,
                           bssq_pkg::INDEX_W'(i)));
    end
    queue_item(make_item(bssq_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 4'd15));
    queue_item(make_item(bssq_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h0001_0000, $urandom, $urandom, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'hFFFF_0000, $urandom, $urandom, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h0002_0000, $urandom, $urandom, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h0003_0000, $urandom, $urandom, 4'd0));
    wait_drained();

    // Shrinking the table below the count drops the highest entries.
    write_register(bssq_pkg::REG_SIZE_IN_USE, 32'd2);
    queue_item(make_item(bssq_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 4'd1));
    queue_item(make_item(bssq_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 4'd2));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h7FFF_FFFE, $urandom, $urandom, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h8000_0000, $urandom, $urandom, 4'd0));
    wait_drained();

    write_register(bssq_pkg::REG_SIZE_IN_USE, 32'd0);
    write_register(bssq_pkg::REG_SCORE_LIMIT, 32'h8000_0000);
    queue_item(make_item(bssq_pkg::FUNC_INSERT, 32'h8000_0000, $urandom, $urandom, 4'd0));
    queue_item(make_item(bssq_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 4'd0));
    wait_drained();

    run_phase(32'h7FFF_FFFF, 5'd16, 0, 300);
    run_phase(32'h0000_0000, 5'd31, 47, 250);
    run_phase($urandom, 5'd1, 28, 150);
    run_phase(32'h8000_0001, 5'd17, 0, 100);
    run_phase($urandom, bssq_pkg::SIZE_W'($urandom_range(1, 16)), 47, 300);
    run_phase(32'h7FFF_FFFF, 5'd8, 28, 350);

    repeat (10) @(posedge clk);
    check_field("results still owed", 32'(expected_results.size()), 32'd0);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bssq_pkg.sv
hdl/bssq_regs.sv
hdl/bssq_ctrl.sv
hdl/bssq_dp.sv
hdl/bounded_sorted_score_queue.sv
hdl/bssq_chk.sv
tb/testbench.sv
